// File: rtl/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic probing hash table core.
// ----------------------------------------------------------------------------
package qpht_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int KEY_BYTES   = 10;
	localparam int KEY_FIELD_W = 40;
	localparam int KEY_W       = 2 * KEY_FIELD_W;
	localparam int KEY_SLOTS   = KEY_W / 8;
	localparam int BYTE_CNT_W  = $clog2(KEY_SLOTS + 1);
	localparam int PAYLOAD_W   = 64;
	localparam int HASH_W      = 32;
	localparam int PROBE_CAP   = 16;
	localparam int PROBE_W     = $clog2(PROBE_CAP + 1);
	localparam int MAXP_W      = 5;
	localparam int OUT_SLOT_W  = 4;
	localparam int OUT_PROBE_W = 4;
	localparam int IDX_SUM_W   = SLOT_W + PROBE_W + 1;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_SEARCH = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_FIELD_W-1:0] key_high;
		logic [KEY_FIELD_W-1:0] key_low;
		logic [PAYLOAD_W-1:0]   payload;
	} entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0]      home;
		logic [KEY_FIELD_W-1:0] key_high;
		logic [KEY_FIELD_W-1:0] key_low;
	} hash_res_t;

endpackage

// File: rtl/qpht_ram.sv
// ----------------------------------------------------------------------------
// qpht_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module qpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/qpht_hash.sv
// ----------------------------------------------------------------------------
// qpht_hash
// Byte-serial key hasher: one key byte per cycle, h = h*31 + byte, stopping
// at the first zero byte, and builds the normalized key on the way.
// ----------------------------------------------------------------------------
module qpht_hash
	import qpht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [KEY_FIELD_W-1:0] key_high,
	input  logic [KEY_FIELD_W-1:0] key_low,
	output logic                   done,
	output hash_res_t              res
);

	logic                  run_q;
	logic                  done_q;
	logic                  ended_q;
	logic [BYTE_CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0]      shift_q;
	logic [KEY_W-1:0]      norm_q;
	logic [HASH_W-1:0]     h_q;
	logic [7:0]            cur_byte;
	logic                  end_now;

	assign cur_byte = shift_q[KEY_W-1 -: 8];
	assign end_now  = ended_q || (cur_byte == 8'd0) ||
		(cnt_q >= BYTE_CNT_W'(KEY_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == BYTE_CNT_W'(KEY_SLOTS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= {key_high, key_low};
			h_q     <= '0;
			ended_q <= 1'b0;
		end else if (run_q) begin
			shift_q <= {shift_q[KEY_W-9:0], 8'd0};
			ended_q <= end_now;
			norm_q  <= {norm_q[KEY_W-9:0], (end_now ? 8'd0 : cur_byte)};
			if (!end_now) begin
				h_q <= (h_q << 5) - h_q + HASH_W'(cur_byte);
			end
		end
	end

	assign done         = done_q;
	assign res.home     = SLOT_W'(h_q % HASH_W'(TABLE_SLOTS));
	assign res.key_high = norm_q[KEY_W-1 -: KEY_FIELD_W];
	assign res.key_low  = norm_q[KEY_FIELD_W-1:0];

endmodule

// File: rtl/quadratic_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing hash table with quadratic probing over a slot RAM.
// ----------------------------------------------------------------------------
// An operation is transferred at a clock edge where start is high and busy is
// low; opcode selects an insert of key_high/key_low with payload, or a search.
// The key is hashed one byte per cycle, then probe a reads slot (home + a*a)
// mod 16, one slot RAM read per cycle, pipelined so that a probe is issued
// while the previous one is evaluated. The result is shown on status,
// slot_index, probe_count and found_payload for exactly one cycle with done
// high; it is transferred at the edge that ends that cycle. A new start is
// taken in the cycle where done is high. max_probes is written through cfg_we
// and cfg_wdata; the user writes it only while the core is idle, which the
// core itself does not enforce. Reset clears all slot valid bits and sets
// max_probes to 16; the slot RAM needs no clearing pass. The receiver cannot
// stall, so results never wait.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core
	import qpht_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   opcode,
	input  logic [KEY_FIELD_W-1:0] key_high,
	input  logic [KEY_FIELD_W-1:0] key_low,
	input  logic [PAYLOAD_W-1:0]   payload,
	input  logic                   cfg_we,
	input  logic [MAXP_W-1:0]      cfg_wdata,
	output logic                   done,
	output logic [1:0]             status,
	output logic [OUT_SLOT_W-1:0]  slot_index,
	output logic [OUT_PROBE_W-1:0] probe_count,
	output logic [PAYLOAD_W-1:0]   found_payload
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_HASH  = 3'b010,
		S_PROBE = 3'b100
	} state_t;

	state_t                 state_q;
	logic [MAXP_W-1:0]      max_probes_q;
	logic [PROBE_W-1:0]     limit_q;
	logic [PROBE_W-1:0]     limit_d;
	opcode_t                op_q;
	logic [PAYLOAD_W-1:0]   payload_q;
	logic [TABLE_SLOTS-1:0] valid_q;

	logic                 hash_done;
	hash_res_t            hres;

	logic [SLOT_W-1:0]    idx_q;
	logic [PROBE_W-1:0]   a_q;
	logic [IDX_SUM_W-1:0] idx_sum;
	logic [SLOT_W-1:0]    idx_next;
	logic                 issue;

	logic                 live_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic [PROBE_W-1:0]   a_s1;
	logic                 vld_s1;

	entry_t               rd_entry;
	entry_t               wr_entry;
	logic                 ram_we;
	logic                 key_match;
	logic                 last_s1;
	logic                 finish;
	status_t              fin_status;
	logic                 fin_slot_hit;
	logic [PROBE_W-1:0]   fin_probes;

	qpht_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !busy),
		.key_high (key_high),
		.key_low  (key_low),
		.done     (hash_done),
		.res      (hres)
	);

	qpht_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (wr_entry),
		.raddr (idx_q),
		.rdata (rd_entry)
	);

	assign busy = (state_q != S_IDLE);

	always_comb begin
		if (max_probes_q == '0) begin
			limit_d = PROBE_W'(1);
		end else if (max_probes_q > MAXP_W'(PROBE_CAP)) begin
			limit_d = PROBE_W'(PROBE_CAP);
		end else begin
			limit_d = PROBE_W'(max_probes_q);
		end
	end

	assign idx_sum  = IDX_SUM_W'(idx_q) + IDX_SUM_W'({a_q, 1'b1});
	assign idx_next = SLOT_W'(idx_sum % IDX_SUM_W'(TABLE_SLOTS));
	assign issue    = (state_q == S_PROBE) && (a_q < limit_q);

	assign key_match = (rd_entry.key_high == hres.key_high) &&
		(rd_entry.key_low == hres.key_low);
	assign last_s1   = (a_s1 == limit_q - 1'b1);

	always_comb begin
		finish       = 1'b0;
		fin_status   = ST_FULL;
		fin_slot_hit = 1'b0;
		fin_probes   = a_s1;
		ram_we       = 1'b0;
		if (live_s1) begin
			case (op_q)
				OP_INSERT: begin
					if (!vld_s1) begin
						finish       = 1'b1;
						fin_status   = ST_INSERTED;
						fin_slot_hit = 1'b1;
						ram_we       = 1'b1;
					end else if (last_s1) begin
						finish     = 1'b1;
						fin_status = ST_FULL;
					end
				end
				OP_SEARCH: begin
					if (!vld_s1) begin
						finish     = 1'b1;
						fin_status = ST_NOT_FOUND;
					end else if (key_match) begin
						finish       = 1'b1;
						fin_status   = ST_FOUND;
						fin_slot_hit = 1'b1;
					end else if (last_s1) begin
						finish     = 1'b1;
						fin_status = ST_NOT_FOUND;
					end
				end
				default: begin
					finish = 1'b0;
				end
			endcase
		end
	end

	assign wr_entry.key_high = hres.key_high;
	assign wr_entry.key_low  = hres.key_low;
	assign wr_entry.payload  = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_probes_q <= MAXP_W'(PROBE_CAP);
			live_s1      <= 1'b0;
			done         <= 1'b0;
			valid_q      <= '0;
		end else begin
			done    <= finish;
			live_s1 <= issue && !finish;
			if (cfg_we) begin
				max_probes_q <= cfg_wdata;
			end
			if (ram_we) begin
				valid_q[idx_s1] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (hash_done) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q      <= opcode_t'(opcode);
			payload_q <= payload;
			limit_q   <= limit_d;
		end
		if (state_q == S_HASH && hash_done) begin
			idx_q <= hres.home;
			a_q   <= '0;
		end else if (issue) begin
			idx_q <= idx_next;
			a_q   <= a_q + 1'b1;
		end
		idx_s1 <= idx_q;
		a_s1   <= a_q;
		vld_s1 <= valid_q[idx_q];
		if (finish) begin
			status        <= fin_status;
			slot_index    <= fin_slot_hit ? OUT_SLOT_W'(idx_s1) : '0;
			probe_count   <= OUT_PROBE_W'(fin_probes);
			found_payload <= (fin_status == ST_FOUND) ? rd_entry.payload : '0;
		end
	end

	a_done_after_probe: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_PROBE))
		else $error("result strobe without a probe phase");

	a_probe_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (PROBE_W'(probe_count) < limit_q))
		else $error("probe count reached the probe limit");

	a_valid_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("slot valid bit was lost");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("core went busy without a start transfer");

endmodule
